// File: rtl/papiq_pkg.sv
package papiq_pkg;

  // Parameter defaults.
  localparam int STAGE_DELAY_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 16;
  localparam int CORDIC_ITER_DEF = 16;

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE = 2'd1;

  // CORDIC number formats: 32-bit binary angle, vectors with 16 fraction bits.
  localparam int ANG_W        = 32;
  localparam int VEC_W        = 34;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] KINV = 32'd2608131496;

  // Queue between the front end and the CORDIC engine.
  localparam int QUEUE_DEPTH = 2;

  // One queued request: a phase to rotate, or a bypassed increment.
  typedef struct packed {
    logic                bypass;
    logic [SAMPLE_W-1:0] value;
  } job_t;

  // Arctangent of 2^-idx as a fraction of a full turn, scaled by 2^32.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Drop 16 fraction bits rounding toward zero, then saturate to 16 bits.
  function automatic logic [SAMPLE_W-1:0] to_sample(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] bias;
    logic signed [VEC_W-1:0] sum;
    logic signed [VEC_W-1:0] r;
    logic [SAMPLE_W-1:0]     q;
    bias = v[VEC_W-1] ? VEC_W'(65535) : '0;
    sum  = v + bias;
    r    = sum >>> 16;
    if (r > 32767) begin
      q = 16'h7FFF;
    end else if (r < -32768) begin
      q = 16'h8000;
    end else begin
      q = r[SAMPLE_W-1:0];
    end
    return q;
  endfunction

endpackage

// File: rtl/papiq_queue.sv
module papiq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  papiq_pkg::job_t    push_job,
  output logic               full,
  input  logic               pop,
  output papiq_pkg::job_t    head_job,
  output logic               not_empty
);

  localparam int PTR_W = $clog2(papiq_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(papiq_pkg::QUEUE_DEPTH + 1);

  papiq_pkg::job_t   slot_r [papiq_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(papiq_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(papiq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(papiq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/papiq_front.sv
module papiq_front #(
  parameter int STAGE_DELAY = papiq_pkg::STAGE_DELAY_DEF,
  parameter int DATA_WIDTH  = papiq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [papiq_pkg::SAMPLE_W-1:0] in_data,
  output logic                          in_ready,
  input  logic                          enable,
  output logic                          push,
  output papiq_pkg::job_t               push_job,
  input  logic                          q_full
);

  logic                           accept;
  logic                           take_old;
  logic                           pend_r, pend_nxt;
  logic [papiq_pkg::SAMPLE_W-1:0] old_r;
  logic [DATA_WIDTH-1:0]          phase_r, phase_nxt;
  logic [DATA_WIDTH-1:0]          phase_sum;

  // The holding stage drains into the queue whenever the queue has room.
  assign in_ready = !pend_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = pend_r && !q_full;

  // Delay line: the increment that entered STAGE_DELAY requests ago.
  if (STAGE_DELAY == 0) begin : g_no_delay
    assign take_old = accept;

    always_ff @(posedge clk) begin
      if (accept) begin
        old_r <= in_data;
      end
    end
  end else begin : g_delay
    localparam int PTR_W  = (STAGE_DELAY > 1) ? $clog2(STAGE_DELAY) : 1;
    localparam int FILL_W = $clog2(STAGE_DELAY + 1);

    logic [papiq_pkg::SAMPLE_W-1:0] line_mem [STAGE_DELAY];
    logic [PTR_W-1:0]               wr_ptr_r, wr_ptr_nxt;
    logic [FILL_W-1:0]              fill_r, fill_nxt;
    logic                           line_full;

    assign line_full = (fill_r == FILL_W'(STAGE_DELAY));
    assign take_old  = accept && line_full;

    always_comb begin
      wr_ptr_nxt = wr_ptr_r;
      fill_nxt   = fill_r;
      if (accept) begin
        wr_ptr_nxt = (wr_ptr_r == PTR_W'(STAGE_DELAY - 1)) ? '0 : wr_ptr_r + 1'b1;
        if (!line_full) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        wr_ptr_r <= '0;
        fill_r   <= '0;
      end else begin
        wr_ptr_r <= wr_ptr_nxt;
        fill_r   <= fill_nxt;
      end
    end

    // Read-before-write at the same address gives the oldest entry.
    always_ff @(posedge clk) begin
      if (accept) begin
        line_mem[wr_ptr_r] <= in_data;
      end
      if (take_old) begin
        old_r <= line_mem[wr_ptr_r];
      end
    end
  end

  // Holding stage occupancy.
  always_comb begin
    priority if (take_old) begin
      pend_nxt = 1'b1;
    end else if (push) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  // Phase accumulator wraps at a full turn; it holds in bypass.
  assign phase_sum = phase_r + old_r[DATA_WIDTH-1:0];
  assign phase_nxt = (push && enable) ? phase_sum : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign push_job.bypass = !enable;
  assign push_job.value  = enable ? papiq_pkg::SAMPLE_W'(phase_sum) : old_r;

endmodule

// File: rtl/papiq_cordic.sv
module papiq_cordic #(
  parameter int DATA_WIDTH        = papiq_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = papiq_pkg::CORDIC_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  papiq_pkg::job_t                 job,
  output logic                            pop,
  input  logic [papiq_pkg::MAG_W-1:0]     magnitude,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2*papiq_pkg::SAMPLE_W-1:0] out_data
);

  localparam int N_ITER = (CORDIC_ITERATIONS > papiq_pkg::ATAN_ENTRIES) ?
                          papiq_pkg::ATAN_ENTRIES : CORDIC_ITERATIONS;
  localparam int CNT_W  = (N_ITER > 1) ? $clog2(N_ITER) : 1;
  localparam int VW     = papiq_pkg::VEC_W;
  localparam int SW     = papiq_pkg::SAMPLE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [VW-1:0]          x_r, x_nxt;
  logic signed [VW-1:0]          y_r, y_nxt;
  logic signed [31:0]            z_r, z_nxt;
  logic [1:0]                    quad_r, quad_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [2*SW-1:0]               out_data_r, out_data_nxt;
  logic                          out_free;
  logic [papiq_pkg::ANG_W-1:0]   angle;
  logic [papiq_pkg::MAG_W+31:0]  prod;
  logic signed [VW-1:0]          dx, dy;
  logic signed [31:0]            atan_s;
  logic signed [VW-1:0]          cos_v, sin_v;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Binary angle; the top two bits pick the quadrant.
  assign angle = papiq_pkg::ANG_W'(job.value[DATA_WIDTH-1:0])
                 << (papiq_pkg::ANG_W - DATA_WIDTH);

  // Start vector carries the inverse CORDIC gain.
  assign prod = magnitude * papiq_pkg::KINV;

  // One rotation step per cycle through a shared shifter.
  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign atan_s = $signed(papiq_pkg::atan_entry(5'(cnt_r)));

  // Undo the quadrant folding.
  always_comb begin
    unique case (quad_r)
      2'd0: begin cos_v = x_r;  sin_v = y_r;  end
      2'd1: begin cos_v = -y_r; sin_v = x_r;  end
      2'd2: begin cos_v = -x_r; sin_v = -y_r; end
      2'd3: begin cos_v = y_r;  sin_v = -x_r; end
    endcase
  end

  // Sequencer: load, iterate, finish into the output register; bypass jobs go straight there.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    quad_nxt      = quad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          if (job.bypass) begin
            if (out_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = {SW'({1'b0, magnitude}), job.value};
            end
          end else begin
            pop       = 1'b1;
            x_nxt     = VW'(prod[papiq_pkg::MAG_W+31:16]);
            y_nxt     = '0;
            z_nxt     = $signed({2'b00, angle[29:0]});
            quad_nxt  = angle[31:30];
            cnt_nxt   = '0;
            state_nxt = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        if (!z_r[31]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_s;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_s;
        end
        if (cnt_r == CNT_W'(N_ITER - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {papiq_pkg::to_sample(sin_v), papiq_pkg::to_sample(cos_v)};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    quad_r     <= quad_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/phase_accumulate_polar_to_iq.sv
// Channel   Direction  tdata fields (lowest bit first)      Notes
// in_       slave      phase_step[15:0]                     signed phase increment
// out_      master     i_out[15:0], q_out[31:16]            signed I/Q samples
// cfg_      write      index 0 enable, index 1 magnitude    no read-back
//
// Throughput: the front end takes one request per clock while its holding stage
// is empty or the queue has room. A rotated sample passes through the shared
// CORDIC engine (a load step with the gain multiply, one step per iteration, a
// finish step), and the engine takes no new request until it has finished; a
// bypass request goes from idle straight into the output register.
// Reset: synchronous, active low; clears the accumulator, fill count and queue.
// Stalls: a two-entry queue and the output register let either side stall alone.
module phase_accumulate_polar_to_iq #(
  parameter int STAGE_DELAY       = papiq_pkg::STAGE_DELAY_DEF,
  parameter int DATA_WIDTH        = papiq_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = papiq_pkg::CORDIC_ITER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // phase_step[15:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // i_out[15:0], q_out[31:16]
  input  logic                              cfg_wr_en,
  input  logic [papiq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [papiq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                        enable_r, enable_nxt;
  logic [papiq_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic                        push;
  papiq_pkg::job_t             push_job;
  logic                        q_full;
  logic                        pop;
  papiq_pkg::job_t             head_job;
  logic                        q_not_empty;

  // Configuration registers.
  always_comb begin
    enable_nxt = enable_r;
    mag_nxt    = mag_r;
    if (cfg_wr_en && cfg_index == papiq_pkg::REG_ENABLE) begin
      enable_nxt = cfg_wdata[0];
    end
    if (cfg_wr_en && cfg_index == papiq_pkg::REG_MAGNITUDE) begin
      mag_nxt = cfg_wdata[papiq_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      mag_r    <= '0;
    end else begin
      enable_r <= enable_nxt;
      mag_r    <= mag_nxt;
    end
  end

  papiq_front #(
    .STAGE_DELAY (STAGE_DELAY),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_ready (in_tready),
    .enable   (enable_r),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  papiq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (q_not_empty)
  );

  papiq_cordic #(
    .DATA_WIDTH        (DATA_WIDTH),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (head_job),
    .pop       (pop),
    .magnitude (mag_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: rtl/papiq_checker.sv
module papiq_checker #(
  parameter int STAGE_DELAY = papiq_pkg::STAGE_DELAY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [31:0]                      out_tdata,
  input logic                             cfg_wr_en,
  input logic [papiq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [papiq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FILL_W = (STAGE_DELAY > 0) ? $clog2(STAGE_DELAY + 1) : 1;

  logic                        in_acc, out_acc, line_full;
  logic [FILL_W-1:0]           fill_r;
  logic [3:0]                  credit_r;
  logic                        en_r;
  logic [papiq_pkg::MAG_W-1:0] mag_r;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign line_full = (fill_r == FILL_W'(STAGE_DELAY));

  // Shadow of the delay-line fill, owed results and the configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      credit_r <= '0;
      en_r     <= 1'b1;
      mag_r    <= '0;
    end else begin
      if (in_acc && !line_full) begin
        fill_r <= fill_r + 1'b1;
      end
      credit_r <= credit_r + 4'((in_acc && line_full) ? 1 : 0) - 4'(out_acc ? 1 : 0);
      if (cfg_wr_en && cfg_index == papiq_pkg::REG_ENABLE) begin
        en_r <= cfg_wdata[0];
      end
      if (cfg_wr_en && cfg_index == papiq_pkg::REG_MAGNITUDE) begin
        mag_r <= cfg_wdata[papiq_pkg::MAG_W-1:0];
      end
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result without a request that has passed the delay line.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> credit_r != 4'd0)
    else $error("result without a matching delayed request");

  // In bypass the quadrature output carries the magnitude.
  a_bypass_q: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !en_r |-> out_tdata[31:16] == {1'b0, mag_r})
    else $error("bypass quadrature output differs from magnitude");

  // Zero amplitude rotates to a zero vector.
  a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && en_r && mag_r == '0 |-> out_tdata == 32'd0)
    else $error("nonzero output at zero magnitude");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind phase_accumulate_polar_to_iq papiq_checker #(
  .STAGE_DELAY (STAGE_DELAY)
) u_papiq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);

// File: dv/tb_top.sv
module tb_top;

  // Spare register indexes; writes to them must have no effect.
  localparam logic [papiq_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [papiq_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int DLY   = papiq_pkg::STAGE_DELAY_DEF;
  localparam int N_ROT = (papiq_pkg::CORDIC_ITER_DEF > papiq_pkg::ATAN_ENTRIES) ?
                         papiq_pkg::ATAN_ENTRIES : papiq_pkg::CORDIC_ITER_DEF;
  // Cycles the block may still be busy after the last result leaves.
  localparam int SETTLE = 2 * (papiq_pkg::CORDIC_ITER_DEF + 2) + 8;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 128;

  // Arctangent of 2^-k in turns scaled by 2^32; entry k sits at bits [32k +: 32].
  localparam logic [24*32-1:0] ATAN_TBL = {
    32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
    32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
    32'h0000517D, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  typedef struct packed {
    logic [papiq_pkg::SAMPLE_W-1:0] q_val;
    logic [papiq_pkg::SAMPLE_W-1:0] i_val;
  } iq_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [papiq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [papiq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: register copies, accumulated phase, delayed increments.
  logic mode_enable = 1'b1;
  logic [papiq_pkg::MAG_W-1:0] amplitude = '0;
  logic [15:0] phase_acc = '0;
  logic [15:0] step_line[$];
  iq_t iq_expected[$];

  // Phase increments waiting to be offered, and bookkeeping counters.
  logic [15:0] pending_steps[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  logic in_taken = 1'b0;

  // Sender burst shaping and receiver stall pattern.
  int burst_left = 0;
  int gap_left = 0;
  int pattern_left = 0;
  int rx_mode = 0;
  int hold_left = 0;
  logic held_once = 1'b0;

  phase_accumulate_polar_to_iq u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // phase_step[15:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // i_out[15:0], q_out[31:16]
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Drop 16 fraction bits toward zero and saturate to a 16-bit sample.
  function automatic logic [papiq_pkg::SAMPLE_W-1:0] trunc_sat(input longint v);
    longint r;
    if (v >= 0) begin
      r = v >>> 16;
    end else begin
      r = -((-v) >>> 16);
    end
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return 16'(r);
  endfunction

  // Rotation CORDIC: amplitude times cosine and sine of a 16-bit phase.
  function automatic iq_t polar_to_iq(input logic [15:0] ph,
                                      input logic [papiq_pkg::MAG_W-1:0] mag);
    logic [63:0] prod;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    iq_t r;
    prod = 64'(mag) * 64'(papiq_pkg::KINV);
    x = longint'(prod >> 16);
    y = 0;
    // Angle within the quadrant: low 30 bits of the 32-bit binary angle.
    z = longint'({34'd0, ph[13:0], 16'd0});
    for (int k = 0; k < N_ROT; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'({32'd0, ATAN_TBL[k*32 +: 32]});
      end else begin
        x += dx;
        y -= dy;
        z += longint'({32'd0, ATAN_TBL[k*32 +: 32]});
      end
    end
    // The top two phase bits pick the quadrant.
    case (ph[15:14])
      2'b00: begin c = x;  s = y;  end
      2'b01: begin c = -y; s = x;  end
      2'b10: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    r.i_val = trunc_sat(c);
    r.q_val = trunc_sat(s);
    return r;
  endfunction

  // Push one increment through the delay line; once it is full, predict a sample.
  function automatic void accumulate_step(input logic [15:0] step);
    logic [15:0] old;
    iq_t r;
    step_line.push_back(step);
    if (step_line.size() > DLY) begin
      old = step_line[0];
      step_line.delete(0);
      if (mode_enable) begin
        phase_acc = phase_acc + old;
        r = polar_to_iq(phase_acc, amplitude);
      end else begin
        r.i_val = old;
        r.q_val = {1'b0, amplitude};
      end
      iq_expected.push_back(r);
    end
  endfunction

  // Monitor: predict on each input request, check each output request.
  always @(posedge clk) begin
    iq_t e;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        n_accepted++;
        accumulate_step(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (iq_expected.size() == 0) begin
          $error("unexpected sample: i_out %0d, q_out %0d",
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
          n_errors++;
        end else begin
          e = iq_expected[0];
          iq_expected.delete(0);
          if (out_tdata[15:0] !== e.i_val) begin
            $error("i_out: expected %0d, got %0d", $signed(e.i_val), $signed(out_tdata[15:0]));
            n_errors++;
          end
          if (out_tdata[31:16] !== e.q_val) begin
            $error("q_out: expected %0d, got %0d", $signed(e.q_val), $signed(out_tdata[31:16]));
            n_errors++;
          end
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_steps.size() != 0) begin
        in_tdata <= pending_steps[0];
        pending_steps.delete(0);
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern redrawn as its countdown ends, plus one long hold-off
  // while plenty of input is still queued so that the block backs up.
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left = 64;
      rx_mode = $urandom_range(0, 3);
    end else begin
      pattern_left--;
    end
    if (!held_once && n_results >= 300 && n_queued - n_accepted > 60) begin
      hold_left = 300;
      held_once = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 9) != 0);
        default: out_tready <= (pattern_left % 4 == 0);
      endcase
    end
  end

  // Register write while the block is idle; the predictor copy follows it.
  task automatic write_reg(input logic [papiq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [papiq_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      papiq_pkg::REG_ENABLE: mode_enable = val[0];
      papiq_pkg::REG_MAGNITUDE: amplitude = val[papiq_pkg::MAG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic push_step(input logic [15:0] step);
    pending_steps.push_back(step);
    n_queued++;
  endtask

  // Wait until every increment is taken and every sample has arrived, then settle.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (n_accepted != n_queued || iq_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Random increment: half the time a steady tone, else full-range, edge or small steps.
  function automatic logic [15:0] pick_step(input logic [15:0] tone);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return tone;
    end else if (r < 8) begin
      return 16'($urandom);
    end else if (r == 8) begin
      case ($urandom_range(0, 5))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        3: return 16'h4000;
        4: return 16'hC000;
        default: return 16'h0000;
      endcase
    end
    return 16'($signed(10'($urandom)));
  endfunction

  initial begin
    logic [15:0] tone;
    logic [papiq_pkg::MAG_W-1:0] amp;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: full amplitude, quadrant edges, extremes and phase wrap.
    write_reg(papiq_pkg::REG_MAGNITUDE, 15'h7FFF);
    write_reg(papiq_pkg::REG_ENABLE, 15'h0001);
    @(posedge clk);
    push_step(16'h0000); push_step(16'h0001); push_step(16'hFFFF); push_step(16'h7FFF);
    push_step(16'h8000); push_step(16'h4000); push_step(16'hC000); push_step(16'h2000);
    push_step(16'h5555); push_step(16'hAAAA); push_step(16'h0001); push_step(16'hFFFE);
    push_step(16'h3FFF); push_step(16'h4001); push_step(16'h7FFE); push_step(16'h8001);
    push_step(16'h0000); push_step(16'hFFFF); push_step(16'h8000); push_step(16'h7FFF);
    push_step(16'h4000); push_step(16'h1234); push_step(16'hEDCB); push_step(16'h0000);
    wait_drained();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          // Writes to spare indexes are ignored; enable takes bit 0 only.
          write_reg(REG_SPARE_A, 15'h7FFF);
          write_reg(REG_SPARE_B, 15'h1234);
          write_reg(papiq_pkg::REG_ENABLE, 15'h7FFE);
          write_reg(papiq_pkg::REG_MAGNITUDE, 15'h0000);
        end
        1: begin
          write_reg(papiq_pkg::REG_ENABLE, 15'h7FFF);
          write_reg(papiq_pkg::REG_MAGNITUDE, 15'h0001);
        end
        2: begin
          write_reg(papiq_pkg::REG_MAGNITUDE, 15'h7FFF);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: amp = '0;
            1: amp = 15'h7FFF;
            default: amp = 15'($urandom);
          endcase
          write_reg(papiq_pkg::REG_ENABLE, 15'($urandom_range(0, 3) != 0));
          write_reg(papiq_pkg::REG_MAGNITUDE, amp);
        end
      endcase
      tone = 16'($urandom);
      @(posedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_step(pick_step(tone));
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/papiq_pkg.sv
rtl/papiq_queue.sv
rtl/papiq_front.sv
rtl/papiq_cordic.sv
rtl/phase_accumulate_polar_to_iq.sv
rtl/papiq_checker.sv
dv/tb_top.sv
